/* rtl/core/lzsd_pkg.sv */
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared constants and types of the LZSS stream decompressor: window geometry,
// match length bounds, status codes and the window access request.
// ----------------------------------------------------------------------------
package lzsd_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int WIN_AW      = $clog2(WINDOW_SIZE);
   localparam int MATCH_MIN   = 3;
   localparam int MATCH_MAX   = 18;
   localparam int LEN_W       = $clog2(MATCH_MAX + 1);

   // first write position of a fresh stream
   localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(WINDOW_SIZE - MATCH_MAX);

   // stream status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TRUNC   = 2'd1;
   localparam logic [1:0] ST_CAP     = 2'd2;
   localparam logic [1:0] ST_OVERRUN = 2'd3;

   // window access request from the decoder
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [WIN_AW-1:0] rd_addr;
   } win_req_type;

endpackage

/* rtl/core/lzsd_window.sv */
// ----------------------------------------------------------------------------
// lzsd_window
// Ring window memory. Writes go to an internal write pointer that advances by
// one per byte. A fill count marks entries written since the last clear, so
// older entries read as zero. A byte written to the read address in the cycle
// of a read is forwarded to that read.
// ----------------------------------------------------------------------------
module lzsd_window
   import lzsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  win_req_type win_req,
   output logic [7:0]  rd_data
);

   logic [7:0]        mem [WINDOW_SIZE];
   logic [7:0]        mem_q_ff;
   logic [WIN_AW-1:0] wp_ff;
   logic [WIN_AW:0]   fill_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;
   logic              valid_ff;
   logic [WIN_AW-1:0] rd_off;
   logic              valid_in;
   logic              fwd_in;

   // offset of the read address from the stream start position
   assign rd_off   = win_req.rd_addr - START_POS;
   assign valid_in = ({1'b0, rd_off} < fill_ff);
   assign fwd_in   = win_req.wr_en && (win_req.rd_addr == wp_ff);

   // storage: read-first, read data held until the next read
   always_ff @(posedge clock) begin
      if (win_req.wr_en) begin
         mem[wp_ff] <= win_req.wr_data;
      end
      if (win_req.rd_en) begin
         mem_q_ff <= mem[win_req.rd_addr];
      end
   end

   // write pointer and fill count
   always_ff @(posedge clock) begin
      if (reset || win_req.clear) begin
         wp_ff   <= START_POS;
         fill_ff <= '0;
      end else if (win_req.wr_en) begin
         wp_ff <= wp_ff + 1'b1;
         if (fill_ff != (WIN_AW+1)'(WINDOW_SIZE)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // capture forwarding and validity with each read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else if (win_req.rd_en) begin
         fwd_ff   <= fwd_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_req.rd_en) begin
         fwd_data_ff <= win_req.wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (valid_ff ? mem_q_ff : 8'h00);

endmodule

/* rtl/core/lzss_stream_decompressor_core.sv */
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core
// LZSS decoder with a 4096-byte ring window: four-byte size header, flag
// bytes LSB first, literals and two-byte matches copied through the window.
//
//   channel  dir  ports                    contents
//   req      in   req_t*                   compressed byte, end of stream
//   rsp      out  rsp_t*                   decoded byte and stream status
//   csr      in   csr_p*                   out_capacity at address 0
//
// Each request byte is latched in C_WAIT and decoded in C_EXEC; a match high
// byte then runs the C_COPY engine, one window read per copied byte.
// Reset is synchronous; the window reads as zero at every stream start through
// its fill count, so no clearing pass is needed.
// A stalled result holds in the output register; the next request is taken
// while it waits, and decoding pauses only when a new result has no room.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_core
   import lzsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [8] stream_done,
                                    // [10:9] status, [42:11] decoded_size
   output logic        rsp_tuser,   // has_byte
   output logic        rsp_tlast,   // run_last
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic CSR_IDX_CAP = 1'b0;

   typedef enum logic [1:0] {C_WAIT, C_EXEC, C_COPY} ctrl_type;
   typedef enum logic [1:0] {P_HEADER, P_TOKEN, P_MATCH_HI, P_IDLE} phase_type;

   ctrl_type          ctrl_ff;
   phase_type         phase_ff;
   logic [31:0]       cap_ff;
   logic [7:0]        item_byte_ff;
   logic              item_last_ff;
   logic [7:0]        flag_bits_ff;
   logic [3:0]        flag_index_ff;
   logic [1:0]        header_count_ff;
   logic [31:0]       remaining_ff;
   logic [31:0]       size_word_ff;
   logic [7:0]        match_low_ff;
   // copy engine
   logic [WIN_AW-1:0] copy_addr_ff;
   logic [LEN_W-1:0]  issue_left_ff;
   logic [LEN_W-1:0]  emit_left_ff;
   logic              pend_ff;
   logic              cp_done_ff;
   logic [1:0]        cp_status_ff;
   logic              cp_last_ff;
   // output register
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_has_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;
   logic [1:0]        rsp_status_ff;
   logic [31:0]       rsp_size_ff;

   logic              out_free;
   logic [31:0]       size_new;
   logic [LEN_W-1:0]  ex_len;
   logic              ex_done;
   logic [1:0]        ex_status;
   logic              ex_literal;
   logic              ex_copy;
   logic              ex_full;
   logic              ex_need_out;
   logic              ex_go;
   logic [31:0]       ex_size_rep;
   logic              cp_emit;
   logic              cp_issue;
   logic              cp_final;
   logic              restart;
   logic              go_idle;
   logic              csr_wr;
   win_req_type       win_req;
   logic [7:0]        win_rd_data;

   lzsd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .rd_data (win_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (ctrl_ff == C_WAIT);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_CAP);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAP) ? cap_ff : 32'h0;

   // decode one latched request byte
   always_comb begin
      size_new    = size_word_ff | (32'(item_byte_ff) << {header_count_ff, 3'b000});
      ex_len      = LEN_W'(item_byte_ff[3:0]) + LEN_W'(MATCH_MIN);
      ex_done     = 1'b0;
      ex_status   = ST_OK;
      ex_literal  = 1'b0;
      ex_copy     = 1'b0;
      ex_full     = 1'b1;
      unique case (phase_ff)
         P_HEADER: begin
            ex_full = (header_count_ff == 2'd3);
            if (header_count_ff == 2'd3) begin
               if (size_new > cap_ff) begin
                  ex_done   = 1'b1;
                  ex_status = ST_CAP;
               end else if (size_new == 32'h0) begin
                  ex_done = 1'b1;
               end
            end
         end
         P_TOKEN: begin
            if (!flag_index_ff[3] && flag_bits_ff[flag_index_ff[2:0]]) begin
               ex_literal = 1'b1;
               ex_done    = (remaining_ff == 32'd1);
            end
         end
         P_MATCH_HI: begin
            if (32'(ex_len) > remaining_ff) begin
               ex_done   = 1'b1;
               ex_status = ST_OVERRUN;
            end else begin
               ex_copy = 1'b1;
            end
         end
         P_IDLE: begin
         end
         default: begin
         end
      endcase
      // end of input before the stream is complete
      if ((phase_ff != P_IDLE) && !ex_done && !ex_copy && item_last_ff) begin
         ex_done   = 1'b1;
         ex_status = ST_TRUNC;
      end
      ex_need_out = ex_done || ex_literal;
      ex_go       = (ctrl_ff == C_EXEC) && (!ex_need_out || out_free);
      if (!ex_full) begin
         ex_size_rep = 32'h0;
      end else if (phase_ff == P_HEADER) begin
         ex_size_rep = size_new;
      end else begin
         ex_size_rep = size_word_ff;
      end
   end

   // copy engine handshake: emit the pending byte, then refill the read slot
   assign cp_emit  = (ctrl_ff == C_COPY) && pend_ff && out_free;
   assign cp_issue = (ctrl_ff == C_COPY) && (issue_left_ff != '0) && (!pend_ff || cp_emit);
   assign cp_final = cp_emit && (emit_left_ff == LEN_W'(1));

   // stream end actions
   always_comb begin
      restart = 1'b0;
      go_idle = 1'b0;
      if (ex_go) begin
         if (phase_ff == P_IDLE) begin
            restart = item_last_ff;
         end else if (ex_done) begin
            restart = item_last_ff;
            go_idle = !item_last_ff;
         end
      end else if (cp_final && cp_done_ff) begin
         restart = cp_last_ff;
         go_idle = !cp_last_ff;
      end
   end

   // window access
   always_comb begin
      win_req.clear   = restart;
      win_req.wr_en   = (ex_go && ex_literal) || cp_emit;
      win_req.wr_data = (ctrl_ff == C_COPY) ? win_rd_data : item_byte_ff;
      win_req.rd_en   = cp_issue;
      win_req.rd_addr = copy_addr_ff;
   end

   // control, decoder state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff         <= C_WAIT;
         phase_ff        <= P_HEADER;
         cap_ff          <= 32'hFFFF_FFFF;
         flag_bits_ff    <= 8'h00;
         flag_index_ff   <= 4'd8;
         header_count_ff <= 2'd0;
         remaining_ff    <= 32'h0;
         size_word_ff    <= 32'h0;
         match_low_ff    <= 8'h00;
         issue_left_ff   <= '0;
         emit_left_ff    <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr) begin
            cap_ff <= csr_pwdata;
         end

         // drop a result once taken
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (ctrl_ff)
            C_WAIT: begin
               if (req_tvalid) begin
                  item_byte_ff <= req_tdata;
                  item_last_ff <= req_tlast;
                  ctrl_ff      <= C_EXEC;
               end
            end
            C_EXEC: begin
               if (ex_go) begin
                  ctrl_ff <= C_WAIT;
                  unique case (phase_ff)
                     P_HEADER: begin
                        size_word_ff <= size_new;
                        if (header_count_ff == 2'd3) begin
                           if (size_new <= cap_ff) begin
                              remaining_ff <= size_new;
                              phase_ff     <= P_TOKEN;
                           end
                        end else begin
                           header_count_ff <= header_count_ff + 2'd1;
                        end
                     end
                     P_TOKEN: begin
                        if (flag_index_ff[3]) begin
                           flag_bits_ff  <= item_byte_ff;
                           flag_index_ff <= 4'd0;
                        end else if (ex_literal) begin
                           flag_index_ff <= flag_index_ff + 4'd1;
                           remaining_ff  <= remaining_ff - 32'd1;
                        end else begin
                           match_low_ff <= item_byte_ff;
                           phase_ff     <= P_MATCH_HI;
                        end
                     end
                     P_MATCH_HI: begin
                        if (ex_copy) begin
                           copy_addr_ff  <= {item_byte_ff[7:4], match_low_ff};
                           issue_left_ff <= ex_len;
                           emit_left_ff  <= ex_len;
                           pend_ff       <= 1'b0;
                           remaining_ff  <= remaining_ff - 32'(ex_len);
                           flag_index_ff <= flag_index_ff + 4'd1;
                           phase_ff      <= P_TOKEN;
                           cp_done_ff    <= (remaining_ff == 32'(ex_len)) || item_last_ff;
                           cp_status_ff  <= ((remaining_ff != 32'(ex_len)) && item_last_ff)
                                            ? ST_TRUNC : ST_OK;
                           cp_last_ff    <= item_last_ff;
                           ctrl_ff       <= C_COPY;
                        end
                     end
                     P_IDLE: begin
                     end
                     default: begin
                     end
                  endcase
                  if (ex_need_out) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_byte_ff   <= ex_literal ? item_byte_ff : 8'h00;
                     rsp_has_ff    <= ex_literal;
                     rsp_last_ff   <= 1'b1;
                     rsp_done_ff   <= ex_done;
                     rsp_status_ff <= ex_status;
                     rsp_size_ff   <= ex_done ? ex_size_rep : 32'h0;
                  end
               end
            end
            C_COPY: begin
               if (cp_issue) begin
                  copy_addr_ff  <= copy_addr_ff + 1'b1;
                  issue_left_ff <= issue_left_ff - LEN_W'(1);
                  pend_ff       <= 1'b1;
               end else if (cp_emit) begin
                  pend_ff <= 1'b0;
               end
               if (cp_emit) begin
                  emit_left_ff  <= emit_left_ff - LEN_W'(1);
                  rsp_valid_ff  <= 1'b1;
                  rsp_byte_ff   <= win_rd_data;
                  rsp_has_ff    <= 1'b1;
                  rsp_last_ff   <= cp_final;
                  rsp_done_ff   <= cp_final && cp_done_ff;
                  rsp_status_ff <= (cp_final && cp_done_ff) ? cp_status_ff : ST_OK;
                  rsp_size_ff   <= (cp_final && cp_done_ff) ? size_word_ff : 32'h0;
               end
               if (cp_final) begin
                  ctrl_ff <= C_WAIT;
               end
            end
            default: begin
               ctrl_ff <= C_WAIT;
            end
         endcase

         // park after a finished stream
         if (go_idle) begin
            phase_ff <= P_IDLE;
         end

         // start a new stream
         if (restart) begin
            phase_ff        <= P_HEADER;
            flag_bits_ff    <= 8'h00;
            flag_index_ff   <= 4'd8;
            header_count_ff <= 2'd0;
            remaining_ff    <= 32'h0;
            size_word_ff    <= 32'h0;
            match_low_ff    <= 8'h00;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_size_ff, rsp_status_ff, rsp_done_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // bytes still to emit equal bytes still to read plus the one in flight
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == C_COPY) |-> (emit_left_ff == issue_left_ff + LEN_W'(pend_ff)))
      else $error("copy engine byte count out of step");

   // the last copied byte hands control back to the request side
   assert property (@(posedge clock) disable iff (reset)
      cp_final |=> (ctrl_ff == C_WAIT))
      else $error("copy did not finish after its last byte");

   // a stream restart leaves the block ready for the next request
   assert property (@(posedge clock) disable iff (reset)
      win_req.clear |=> (ctrl_ff == C_WAIT) && (phase_ff == P_HEADER))
      else $error("stream restart left decoder busy");

   // a new result is loaded only when the output register has room
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cp_emit || (ex_go && ex_need_out)))
      else $error("result loaded over a waiting result");
`endif

endmodule

/* tb/tb_lzss_stream_decompressor_core.sv */
// ----------------------------------------------------------------------------
// tb_lzss_stream_decompressor_core
// Self-checking bench for the LZSS stream decompressor. A short table of hand
// built streams comes first: zero size, literals with an overlapping window
// copy, a match that runs past the size, a cut header and a size over the
// capacity. Random compressed streams follow under several capacity settings.
// Each accepted request runs through a bench-side decoder with its own window.
// Every decoded result is checked field by field against the oldest expected
// result. Sender gaps, receiver stalls and one long receiver hold-off are used.
// ----------------------------------------------------------------------------
module tb_lzss_stream_decompressor_core
   import lzsd_pkg::*;
();

   localparam int N_DIRECTED       = 30;
   localparam int RANDOM_PER_PHASE = 50;
   localparam int N_PHASES         = 5;
   localparam int DRAIN_CYCLES     = 32;
   localparam int HOLD_CYCLES      = 300;
   localparam int STALL_LIMIT      = 5000;
   localparam int REG_OUT_CAPACITY = 0;

   typedef enum logic [1:0] {SEQ_SIZE, SEQ_TOKEN, SEQ_MATCH_HI, SEQ_SKIP} decode_seq_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        has_data;
      logic        run_end;
      logic        done;
      logic [1:0]  status;
      logic [31:0] size;
   } decoded_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;   // request byte, or register value for a CSR row
      logic         last;
      logic         check;   // expected result typed in below
      logic [1:0]   status;
      logic [31:0]  size;
   } stim_row_type;

   // hand-built streams; typed rows each end a stream with one marker result
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // zero size, then one trailing request that closes the stream
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b1, ST_OK,      32'd0},
      '{ROW_ITEM, 32'hAB, 1'b1, 1'b0, ST_OK,      32'd0},
      // size 8: literals, overlapping copy from the start position, literal
      '{ROW_ITEM, 32'h08, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'hFB, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'hFF, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'hEE, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'hF2, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h5A, 1'b1, 1'b0, ST_OK,      32'd0},
      // size 3 with a longest match: overrun, trailing byte closes
      '{ROW_ITEM, 32'h03, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h0F, 1'b0, 1'b1, ST_OVERRUN, 32'd3},
      '{ROW_ITEM, 32'h12, 1'b1, 1'b0, ST_OK,      32'd0},
      // stream cut on its first header byte
      '{ROW_ITEM, 32'hFF, 1'b1, 1'b1, ST_TRUNC,   32'd0},
      // zero capacity rejects size 1, then restore the widest capacity
      '{ROW_CSR,  32'h0,  1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h01, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b0, 1'b0, ST_OK,      32'd0},
      '{ROW_ITEM, 32'h00, 1'b1, 1'b1, ST_CAP,     32'd1},
      '{ROW_CSR,  32'hFFFF_FFFF, 1'b0, 1'b0, ST_OK, 32'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // in_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [7:0] out_byte, [8] stream_done,
                                     // [10:9] status, [42:11] decoded_size
   logic        rsp_tuser;           // has_byte
   logic        rsp_tlast;           // run_last
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bench-side decoder state
   logic [7:0]        win_mem [WINDOW_SIZE];
   logic [WIN_AW-1:0] wr_pos;
   logic [7:0]        flags;
   int unsigned       flag_idx;
   decode_seq_type    seq;
   int unsigned       hdr_cnt;
   logic [31:0]       left;
   logic [31:0]       size_hdr;
   logic [7:0]        mlow;
   logic [31:0]       cap_reg;

   decoded_type    step_q [$];
   decoded_type    decoded_q [$];
   req_beat_type   stream_q [$];

   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned decoded_items = 0;
   int unsigned ignored_items = 0;
   int unsigned cap_writes = 0;
   int unsigned endings [4] = '{0, 0, 0, 0};
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;
   bit          hold_req = 1'b0;

   lzss_stream_decompressor_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // count failures; only the first few are printed
   function automatic bit report_next();
      mismatches++;
      return mismatches <= 10;
   endfunction

   // clear the window and rewind the decoder for a fresh stream
   task automatic restart_stream();
      for (int i = 0; i < WINDOW_SIZE; i++) win_mem[i] = 8'h00;
      wr_pos   = START_POS;
      flags    = 8'h00;
      flag_idx = 8;
      seq      = SEQ_SIZE;
      hdr_cnt  = 0;
      left     = 32'd0;
      size_hdr = 32'd0;
      mlow     = 8'h00;
   endtask

   // decode one byte into the window and queue it as a result
   task automatic put_byte(input logic [7:0] b);
      decoded_type r;
      win_mem[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
      r = '0;
      r.data = b;
      r.has_data = 1'b1;
      step_q.push_back(r);
      left = left - 1;
   endtask

   // advance the decoder by one request; results land in step_q
   task automatic decode_byte(input logic [7:0] b, input logic l, output bit counted);
      bit                fin;
      bit                hdr_full;
      logic [1:0]        st;
      logic [WIN_AW-1:0] pos;
      int unsigned       len;
      int unsigned       idx;
      decoded_type       r;
      step_q.delete();
      fin = 1'b0;
      hdr_full = 1'b1;
      st = ST_OK;
      counted = (seq != SEQ_SKIP);
      if (seq == SEQ_SKIP) begin
         // drop trailing bytes until the stream closes
         if (l) restart_stream();
      end else begin
         case (seq)
            SEQ_SIZE: begin
               size_hdr[8*hdr_cnt +: 8] = b;
               if (hdr_cnt == 3) begin
                  if (size_hdr > cap_reg) begin
                     fin = 1'b1;
                     st = ST_CAP;
                  end else begin
                     left = size_hdr;
                     seq = SEQ_TOKEN;
                     if (left == 0) fin = 1'b1;
                  end
               end else begin
                  hdr_cnt++;
                  hdr_full = 1'b0;
               end
            end
            SEQ_TOKEN: begin
               if (flag_idx >= 8) begin
                  flags = b;
                  flag_idx = 0;
               end else if (flags[flag_idx]) begin
                  put_byte(b);
                  flag_idx++;
                  if (left == 0) fin = 1'b1;
               end else begin
                  mlow = b;
                  seq = SEQ_MATCH_HI;
               end
            end
            default: begin
               pos = {b[7:4], mlow};
               len = int'(b[3:0]) + MATCH_MIN;
               if (len > left) begin
                  fin = 1'b1;
                  st = ST_OVERRUN;
               end else begin
                  for (int j = 0; j < len; j++) put_byte(win_mem[pos + WIN_AW'(j)]);
                  flag_idx++;
                  seq = SEQ_TOKEN;
                  if (left == 0) fin = 1'b1;
               end
            end
         endcase
         if (!fin && l) begin
            fin = 1'b1;
            st = ST_TRUNC;
         end
         // mark the end of the stream on the last result of this request
         if (fin) begin
            if (step_q.size() == 0) begin
               r = '0;
               step_q.push_back(r);
            end
            idx = step_q.size() - 1;
            r = step_q[idx];
            r.done = 1'b1;
            r.status = st;
            r.size = hdr_full ? size_hdr : 32'd0;
            step_q[idx] = r;
            if (l) restart_stream();
            else seq = SEQ_SKIP;
         end
         if (step_q.size() > 0) begin
            idx = step_q.size() - 1;
            r = step_q[idx];
            r.run_end = 1'b1;
            step_q[idx] = r;
         end
      end
   endtask

   // offer one request in bursts, then record what it should produce
   task automatic issue_request(input logic [7:0] b, input logic l, input bit typed,
                                input decoded_type typed_res);
      int unsigned gap;
      bit          counted;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      decode_byte(b, l, counted);
      if (counted) decoded_items++;
      else ignored_items++;
      if (typed) decoded_q.push_back(typed_res);
      else foreach (step_q[i]) decoded_q.push_back(step_q[i]);
   endtask

   // hold the request side until all results are out and the block is quiet
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the capacity register, then read it back
   task automatic csr_write(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 3'(4 * REG_OUT_CAPACITY);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cap_reg = value;
      cap_writes++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value && report_next())
         $display("capacity read back %h, wrote %h", csr_prdata, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // build one compressed stream in stream_q, mostly well formed
   task automatic compose_stream();
      logic [31:0]       size;
      logic [WIN_AW-1:0] pos;
      logic [7:0]        fl;
      req_beat_type      beat;
      int unsigned       rem, made, len, back, flag_at, cut, n;
      bit                noise;
      bit                over;
      stream_q.delete();
      noise = 1'b0;
      case ($urandom_range(0, 11))
         0: size = 32'd0;
         1: size = $urandom;
         2: size = cap_reg;
         3: size = cap_reg + 32'd1;
         4: begin
            size = 32'd0;
            noise = 1'b1;
         end
         default: size = $urandom_range(1, 48);
      endcase
      if (noise) begin
         repeat ($urandom_range(1, 12)) stream_q.push_back({8'($urandom), 1'b0});
      end else begin
         for (int k = 0; k < 4; k++) stream_q.push_back({size[8*k +: 8], 1'b0});
         // huge sizes get a short body and end truncated
         rem = (size > 64) ? $urandom_range(4, 30) : size;
         made = 0;
         over = 1'b0;
         while (rem > 0 && !over) begin
            flag_at = stream_q.size();
            fl = 8'($urandom);
            stream_q.push_back({fl, 1'b0});
            for (int k = 0; k < 8 && rem > 0 && !over; k++) begin
               // near the end turn most matches into literals
               if (!fl[k] && rem < 3 && $urandom_range(0, 3) != 0) begin
                  fl[k] = 1'b1;
                  stream_q[flag_at] = {fl, 1'b0};
               end
               if (fl[k]) begin
                  stream_q.push_back({8'($urandom), 1'b0});
                  rem--;
                  made++;
               end else begin
                  if (rem >= 3 && $urandom_range(0, 11) != 0)
                     len = $urandom_range(MATCH_MIN, rem < MATCH_MAX ? rem : MATCH_MAX);
                  else
                     len = $urandom_range(MATCH_MIN, MATCH_MAX);
                  // mostly copy from recently decoded bytes
                  if (made > 0 && $urandom_range(0, 3) != 0) begin
                     back = $urandom_range(1, made < 40 ? made : 40);
                     pos = WIN_AW'(START_POS + made - back);
                  end else begin
                     pos = WIN_AW'($urandom);
                  end
                  stream_q.push_back({pos[7:0], 1'b0});
                  stream_q.push_back({pos[11:8], 4'(len - MATCH_MIN), 1'b0});
                  if (len > rem) begin
                     over = 1'b1;
                  end else begin
                     rem -= len;
                     made += len;
                  end
               end
            end
         end
      end
      // cut short, pad with trailing bytes, or leave as built
      case ($urandom_range(0, 7))
         0: if (stream_q.size() > 1) begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end
         1: repeat ($urandom_range(1, 3)) stream_q.push_back({8'($urandom), 1'b0});
         default: ;
      endcase
      n = stream_q.size() - 1;
      beat = stream_q[n];
      beat.last = 1'b1;
      stream_q[n] = beat;
   endtask

   // receiver: changing stall rate, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned stall_pct, hold_left, span;
      stall_pct = 0;
      hold_left = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (span == 0) begin
            span = $urandom_range(20, 120);
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 25;
               3: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin : rsp_check
      decoded_type got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.data     = rsp_tdata[7:0];
         got.has_data = rsp_tuser;
         got.run_end  = rsp_tlast;
         got.done     = rsp_tdata[8];
         got.status   = rsp_tdata[10:9];
         got.size     = rsp_tdata[42:11];
         results_seen++;
         if (got.done === 1'b1) endings[got.status]++;
         if (decoded_q.size() == 0) begin
            if (report_next())
               $display("unexpected result %0d: byte %h has %b tdata %h", results_seen,
                        got.data, got.has_data, rsp_tdata);
         end else begin
            want = decoded_q.pop_front();
            if (got !== want && report_next())
               $display({"result %0d: want byte %h has %b last %b done %b st %0d size %h,",
                         " got byte %h has %b last %b done %b st %0d size %h"},
                        results_seen, want.data, want.has_data, want.run_end, want.done,
                        want.status, want.size, got.data, got.has_data, got.run_end,
                        got.done, got.status, got.size);
         end
      end
   end

   // watchdog: count cycles in which neither channel moves
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int unsigned budget;
      decoded_type r;
      cap_reg = 32'hFFFF_FFFF;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            settle_block();
            csr_write(DIRECTED[i].value);
         end else begin
            r = '0;
            r.run_end = 1'b1;
            r.done = 1'b1;
            r.status = DIRECTED[i].status;
            r.size = DIRECTED[i].size;
            issue_request(DIRECTED[i].value[7:0], DIRECTED[i].last, DIRECTED[i].check, r);
         end
      end

      // random streams; each phase after the first writes a new capacity
      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            settle_block();
            case (ph)
               1: csr_write($urandom_range(16, 48));
               2: csr_write(32'd0);
               3: csr_write($urandom);
               default: csr_write(32'hFFFF_FFFF);
            endcase
         end
         if (ph == 1) hold_req = 1'b1;
         // budget counts every request sent, decoded or ignored
         budget = decoded_items + ignored_items + RANDOM_PER_PHASE;
         while (decoded_items + ignored_items < budget) begin
            compose_stream();
            foreach (stream_q[k]) issue_request(stream_q[k].data, stream_q[k].last, 1'b0, '0);
         end
      end

      settle_block();
      $display("Covered %0d decoded and %0d ignored requests, %0d results, %0d capacity writes.",
               decoded_items, ignored_items, results_seen, cap_writes);
      $display("Stream endings: ok %0d, truncated %0d, over capacity %0d, match overrun %0d.",
               endings[ST_OK], endings[ST_TRUNC], endings[ST_CAP], endings[ST_OVERRUN]);
      if (mismatches == 0 && decoded_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
